// ----- rtl/w4a8dp_pkg.sv -----
// Shared types and constants for the int8 x int4 dot-product accumulator.
`default_nettype none

package w4a8dp_pkg;

    localparam int LANES      = 8;   // lanes that take part (1 to 8)
    localparam int ACT_FIELDS = 8;   // activation fields carried by one transaction
    localparam int USED_LANES = (LANES < ACT_FIELDS) ? LANES : ACT_FIELDS;

    localparam int ACT_W  = 8;
    localparam int NIB_W  = 4;
    localparam int WORD_W = 32;
    localparam int ACC_W  = 32;
    localparam int PROD_W = ACT_W + NIB_W;
    localparam int SUM_W  = PROD_W + 3;  // room for eight lane products

    localparam int IN_DATA_W  = ACT_FIELDS * ACT_W + WORD_W + ACC_W;
    localparam int OUT_DATA_W = ACC_W;

    // Operands of one chunk as held in the input register
    typedef struct packed {
        logic [ACC_W-1:0]                  partial;
        logic [WORD_W-1:0]                 weight_word;
        logic [ACT_FIELDS-1:0][ACT_W-1:0]  act;
        logic                              first;
        logic                              last;
    } t_item;

endpackage

`default_nettype wire

// ----- rtl/w4a8dp_lane_sum.sv -----
// Lane multipliers and adder tree: sum of int8 activations times signed nibbles.
`default_nettype none

module w4a8dp_lane_sum
    import w4a8dp_pkg::*;
(
    input  wire t_item                    i_item,
    output logic signed [SUM_W-1:0]       o_lane_sum
);

    logic signed [PROD_W-1:0] w_prod [USED_LANES];

    always_comb begin
        for (int j = 0; j < USED_LANES; j++) begin
            w_prod[j] = $signed(i_item.act[j]) *
                        $signed(i_item.weight_word[NIB_W*j +: NIB_W]);
        end
    end

    always_comb begin
        o_lane_sum = '0;
        for (int j = 0; j < USED_LANES; j++) begin
            o_lane_sum = o_lane_sum + SUM_W'(w_prod[j]);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/w4a8_dot_product_accumulate_core.sv -----
// Top level: int8 x int4 dot-product accumulator with stream ports.
//
//  channel   dir  payload                                          when
//  s_axis    in   tdata act0..act7, weight_word, partial_in;       every chunk
//                 tuser first; tlast last
//  m_axis    out  tdata dot_sum                                    chunk with last
//
//  One chunk per cycle sustained unless a chunk carrying last waits on a
//  stalled output; a result goes through the input register, then lane
//  products, adder tree and the 32-bit accumulate into the result register.
//  Synchronous active-low reset clears both valid flags and the accumulator.
//  A stalled output only holds back a chunk that carries last; other chunks
//  keep flowing into the accumulator.
`default_nettype none

module w4a8_dot_product_accumulate_core
    import w4a8dp_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,

    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    // act0..act7 [63:0], weight_word [95:64], partial_in [127:96]
    input  wire  [IN_DATA_W-1:0]  s_axis_tdata,
    // first
    input  wire                   s_axis_tuser,
    input  wire                   s_axis_tlast,

    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    // dot_sum [31:0]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_item                   r_item;
    logic                    r_item_valid;
    logic [ACC_W-1:0]        r_acc;
    logic [ACC_W-1:0]        r_out;
    logic                    r_out_valid;

    logic signed [SUM_W-1:0] w_lane_sum;
    logic [ACC_W-1:0]        n_acc;
    logic                    w_out_free;
    logic                    w_item_go;
    logic                    w_in_take;

    w4a8dp_lane_sum u_lane_sum (
        .i_item     (r_item),
        .o_lane_sum (w_lane_sum)
    );

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_item_go     = r_item_valid && (!r_item.last || w_out_free);
    assign s_axis_tready = !r_item_valid || w_item_go;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_acc = (r_item.first ? r_item.partial : r_acc) + ACC_W'(w_lane_sum);
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_item_valid <= s_axis_tvalid;
        end
        if (w_in_take) begin
            r_item.act         <= s_axis_tdata[ACT_FIELDS*ACT_W-1:0];
            r_item.weight_word <= s_axis_tdata[ACT_FIELDS*ACT_W +: WORD_W];
            r_item.partial     <= s_axis_tdata[ACT_FIELDS*ACT_W+WORD_W +: ACC_W];
            r_item.first       <= s_axis_tuser;
            r_item.last        <= s_axis_tlast;
        end
    end

    // accumulator and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_item_go) begin
                r_acc <= n_acc;
            end
            if (w_item_go && r_item.last) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_item_go && r_item.last) begin
            r_out <= n_acc;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // a closing chunk leaves its sum both in the accumulator and on the output
    a_result_matches_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_item_go && r_item.last |=> m_axis_tvalid && (m_axis_tdata == r_acc))
        else $error("result differs from accumulator");

    a_acc_only_on_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_item_go |=> $stable(r_acc))
        else $error("accumulator changed without a chunk");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_item_valid |-> s_axis_tready)
        else $error("input stalled with empty input register");

    a_nonlast_never_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_item_valid && !r_item.last |-> s_axis_tready)
        else $error("non-closing chunk held back");

endmodule

`default_nettype wire
